FILE: src/floor_ceiling_span_mapper_macros.svh
// ----------------------------------------------------------------------------
// Floor and ceiling span mapper assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FLOOR_CEILING_SPAN_MAPPER_MACROS_SVH
`define FLOOR_CEILING_SPAN_MAPPER_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during rst.
`define FCSM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet during rst.
`define FCSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fcsm_pkg.sv
// ----------------------------------------------------------------------------
// Floor and ceiling span mapper package
// Types, codes and default sizes shared by the span mapper modules.
// ----------------------------------------------------------------------------
package fcsm_pkg;

  localparam int MAX_SPAN_DEF      = 64;
  localparam int TEXTURE_BYTES_DEF = 8192;
  localparam int ADDR_BITS_DEF     = 24;

  localparam int ADDR_W  = 24;
  localparam int COUNT_W = 7;
  localparam int FRAC_W  = 16;
  localparam int INDEX_W = 13;
  localparam int PIXEL_W = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_DRAW_MODE    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHADE_ENABLE = 4'd1;

  typedef enum logic [1:0] {
    OP_LOAD_TEXTURE = 2'd0,
    OP_LOAD_SHADE   = 2'd1,
    OP_DRAW_SPAN    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    DRAW_CEILING = 2'd0,
    DRAW_FLOOR   = 2'd1,
    DRAW_BOTH    = 2'd2
  } draw_mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ADDR_W-1:0] caddr;
    logic [ADDR_W-1:0] faddr;
  } column_t;

endpackage

FILE: src/fcsm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module fcsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: src/fcsm_walker.sv
// ----------------------------------------------------------------------------
// Span walker
// Steps the packed texture accumulator and the screen address one column
// per cycle and issues the two texture reads for each column.
// ----------------------------------------------------------------------------
module fcsm_walker #(
  parameter int MAX_SPAN  = fcsm_pkg::MAX_SPAN_DEF,
  parameter int ADDR_BITS = fcsm_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [fcsm_pkg::ADDR_W-1:0]     dest_offset,
  input  logic [fcsm_pkg::COUNT_W-1:0]    span_count,
  input  logic [fcsm_pkg::FRAC_W-1:0]     x_frac,
  input  logic [fcsm_pkg::FRAC_W-1:0]     y_frac,
  input  logic [fcsm_pkg::FRAC_W-1:0]     x_step,
  input  logic [fcsm_pkg::FRAC_W-1:0]     y_step,
  input  logic [fcsm_pkg::ADDR_W-1:0]     row_offset,
  output logic [fcsm_pkg::INDEX_W-1:0]    ceil_index,
  output logic [fcsm_pkg::INDEX_W-1:0]    floor_index,
  output fcsm_pkg::column_t               column,
  output logic                            active
);

  localparam int AW_EFF = (ADDR_BITS < fcsm_pkg::ADDR_W) ? ADDR_BITS : fcsm_pkg::ADDR_W;
  localparam logic [fcsm_pkg::ADDR_W-1:0] AMASK =
    fcsm_pkg::ADDR_W'((64'd1 << AW_EFF) - 64'd1);

  fcsm_pkg::state_t state, state_next;

  logic [31:0]                      acc;
  logic [31:0]                      step;
  logic [fcsm_pkg::ADDR_W-1:0]      caddr;
  logic [fcsm_pkg::ADDR_W-1:0]      rowofs;
  logic [fcsm_pkg::COUNT_W-1:0]     remaining;
  logic [fcsm_pkg::COUNT_W-1:0]     count_sat;
  logic                             issue;
  logic                             final_col;

  assign count_sat = (span_count > fcsm_pkg::COUNT_W'(MAX_SPAN)) ?
                     fcsm_pkg::COUNT_W'(MAX_SPAN) : span_count;
  assign final_col = (remaining == fcsm_pkg::COUNT_W'(1));
  assign active    = (state == fcsm_pkg::ST_RUN);

  assign ceil_index  = {acc[15:10], acc[31:26], 1'b0};
  assign floor_index = {acc[15:10], acc[31:26], 1'b1};

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    case (state)
      fcsm_pkg::ST_IDLE: begin
        if (load && (count_sat != '0)) begin
          state_next = fcsm_pkg::ST_RUN;
        end
      end
      fcsm_pkg::ST_RUN: begin
        issue = 1'b1;
        if (final_col) begin
          state_next = fcsm_pkg::ST_IDLE;
        end
      end
      default: state_next = fcsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcsm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column.valid <= 1'b0;
    end else begin
      column.valid <= issue;
    end
    if (issue) begin
      column.last  <= final_col;
      column.caddr <= caddr;
      column.faddr <= (caddr + rowofs) & AMASK;
      acc          <= acc + step;
      caddr        <= (caddr + fcsm_pkg::ADDR_W'(1)) & AMASK;
      remaining    <= remaining - fcsm_pkg::COUNT_W'(1);
    end else if (load) begin
      acc       <= {y_frac, x_frac};
      step      <= {y_step, x_step};
      caddr     <= dest_offset & AMASK;
      rowofs    <= row_offset;
      remaining <= count_sat;
    end
  end

endmodule

FILE: src/fcsm_shader.sv
// ----------------------------------------------------------------------------
// Shade and output stage
// Looks the raw texels up in the shade table when shade_enable is set, else
// passes them through, and registers each column as one result.
// ----------------------------------------------------------------------------
module fcsm_shader (
  input  logic                            clk,
  input  logic                            rst,
  input  fcsm_pkg::column_t               column,
  input  logic [fcsm_pkg::PIXEL_W-1:0]    tex_ceil,
  input  logic [fcsm_pkg::PIXEL_W-1:0]    tex_floor,
  output logic [fcsm_pkg::PIXEL_W-1:0]    shade_raddr_a,
  output logic [fcsm_pkg::PIXEL_W-1:0]    shade_raddr_b,
  input  logic [fcsm_pkg::PIXEL_W-1:0]    shade_ceil,
  input  logic [fcsm_pkg::PIXEL_W-1:0]    shade_floor,
  input  logic [1:0]                      draw_mode,
  input  logic                            shade_enable,
  output logic                            pending,
  output logic                            strobe,
  output logic [fcsm_pkg::ADDR_W-1:0]     ceiling_address,
  output logic                            ceiling_valid,
  output logic [fcsm_pkg::PIXEL_W-1:0]    ceiling_pixel,
  output logic [fcsm_pkg::ADDR_W-1:0]     floor_address,
  output logic                            floor_valid,
  output logic [fcsm_pkg::PIXEL_W-1:0]    floor_pixel,
  output logic                            last
);

  fcsm_pkg::column_t                stage;
  logic [fcsm_pkg::PIXEL_W-1:0]     raw_ceil;
  logic [fcsm_pkg::PIXEL_W-1:0]     raw_floor;
  logic                             do_ceil;
  logic                             do_floor;
  logic [fcsm_pkg::PIXEL_W-1:0]     ceil_color;
  logic [fcsm_pkg::PIXEL_W-1:0]     floor_color;

  assign shade_raddr_a = tex_ceil;
  assign shade_raddr_b = tex_floor;
  assign pending       = stage.valid;

  assign do_ceil  = (draw_mode == fcsm_pkg::DRAW_CEILING) || (draw_mode == fcsm_pkg::DRAW_BOTH);
  assign do_floor = (draw_mode == fcsm_pkg::DRAW_FLOOR) || (draw_mode == fcsm_pkg::DRAW_BOTH);

  assign ceil_color  = shade_enable ? shade_ceil : raw_ceil;
  assign floor_color = shade_enable ? shade_floor : raw_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid   <= 1'b0;
      strobe        <= 1'b0;
      ceiling_valid <= 1'b0;
      floor_valid   <= 1'b0;
      last          <= 1'b0;
    end else begin
      stage.valid   <= column.valid;
      strobe        <= stage.valid;
      ceiling_valid <= stage.valid && do_ceil;
      floor_valid   <= stage.valid && do_floor;
      last          <= stage.valid && stage.last;
    end
    stage.last      <= column.last;
    stage.caddr     <= column.caddr;
    stage.faddr     <= column.faddr;
    raw_ceil        <= tex_ceil;
    raw_floor       <= tex_floor;
    ceiling_address <= stage.caddr;
    floor_address   <= stage.faddr;
    ceiling_pixel   <= do_ceil ? ceil_color : '0;
    floor_pixel     <= do_floor ? floor_color : '0;
  end

endmodule

FILE: src/floor_ceiling_span_mapper.sv
// ----------------------------------------------------------------------------
// Floor and ceiling span mapper
// Affine texture mapper that turns one span item into one result per column.
// ----------------------------------------------------------------------------
// A load item is written into its table as it is taken. A span of N columns
// keeps busy high until its last column has left the shade stage, so no new
// item is taken while a span is in flight. The first result passes the column
// register, the registered read of the texture store and then of the shade
// table, and the rest follow one per cycle, paced by the shared accumulator
// adder, which advances one column per cycle. Results are strobed for one
// cycle and cannot be held off, so a receiver must take every result as it
// comes.
module floor_ceiling_span_mapper #(
  parameter int MAX_SPAN      = fcsm_pkg::MAX_SPAN_DEF,
  parameter int TEXTURE_BYTES = fcsm_pkg::TEXTURE_BYTES_DEF,
  parameter int ADDR_BITS     = fcsm_pkg::ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         op,
  input  logic [fcsm_pkg::INDEX_W-1:0]       table_addr,
  input  logic [fcsm_pkg::PIXEL_W-1:0]       table_data,
  input  logic [fcsm_pkg::ADDR_W-1:0]        dest_offset,
  input  logic [fcsm_pkg::COUNT_W-1:0]       span_count,
  input  logic [fcsm_pkg::FRAC_W-1:0]        x_frac,
  input  logic [fcsm_pkg::FRAC_W-1:0]        y_frac,
  input  logic [fcsm_pkg::FRAC_W-1:0]        x_step,
  input  logic [fcsm_pkg::FRAC_W-1:0]        y_step,
  input  logic [fcsm_pkg::ADDR_W-1:0]        row_offset,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fcsm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fcsm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               strobe,
  output logic [fcsm_pkg::ADDR_W-1:0]        ceiling_address,
  output logic                               ceiling_valid,
  output logic [fcsm_pkg::PIXEL_W-1:0]       ceiling_pixel,
  output logic [fcsm_pkg::ADDR_W-1:0]        floor_address,
  output logic                               floor_valid,
  output logic [fcsm_pkg::PIXEL_W-1:0]       floor_pixel,
  output logic                               last
);

  `include "floor_ceiling_span_mapper_macros.svh"

  localparam int TEX_AW = $clog2(TEXTURE_BYTES);

  logic                             accept;
  logic                             draw_load;
  logic                             tex_we;
  logic                             shade_we;
  logic [1:0]                       draw_mode;
  logic                             shade_enable;
  logic                             active;
  logic                             pending;
  logic [fcsm_pkg::INDEX_W-1:0]     ceil_index;
  logic [fcsm_pkg::INDEX_W-1:0]     floor_index;
  fcsm_pkg::column_t                column;
  logic [fcsm_pkg::PIXEL_W-1:0]     tex_ceil;
  logic [fcsm_pkg::PIXEL_W-1:0]     tex_floor;
  logic [fcsm_pkg::PIXEL_W-1:0]     shade_raddr_a;
  logic [fcsm_pkg::PIXEL_W-1:0]     shade_raddr_b;
  logic [fcsm_pkg::PIXEL_W-1:0]     shade_ceil;
  logic [fcsm_pkg::PIXEL_W-1:0]     shade_floor;

  assign busy      = active || column.valid || pending;
  assign accept    = start && !busy;
  assign draw_load = accept && (op == fcsm_pkg::OP_DRAW_SPAN);
  assign tex_we    = accept && (op == fcsm_pkg::OP_LOAD_TEXTURE);
  assign shade_we  = accept && (op == fcsm_pkg::OP_LOAD_SHADE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_mode    <= fcsm_pkg::DRAW_BOTH;
      shade_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == fcsm_pkg::CFG_DRAW_MODE) begin
        draw_mode <= cfg_data[1:0];
      end else if (cfg_index == fcsm_pkg::CFG_SHADE_ENABLE) begin
        shade_enable <= cfg_data[0];
      end
    end
  end

  fcsm_walker #(
    .MAX_SPAN  (MAX_SPAN),
    .ADDR_BITS (ADDR_BITS)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .load        (draw_load),
    .dest_offset (dest_offset),
    .span_count  (span_count),
    .x_frac      (x_frac),
    .y_frac      (y_frac),
    .x_step      (x_step),
    .y_step      (y_step),
    .row_offset  (row_offset),
    .ceil_index  (ceil_index),
    .floor_index (floor_index),
    .column      (column),
    .active      (active)
  );

  fcsm_ram #(
    .WIDTH (fcsm_pkg::PIXEL_W),
    .DEPTH (TEXTURE_BYTES)
  ) u_texture (
    .clk     (clk),
    .we      (tex_we),
    .waddr   (table_addr[TEX_AW-1:0]),
    .wdata   (table_data),
    .raddr_a (ceil_index[TEX_AW-1:0]),
    .raddr_b (floor_index[TEX_AW-1:0]),
    .rdata_a (tex_ceil),
    .rdata_b (tex_floor)
  );

  fcsm_ram #(
    .WIDTH (fcsm_pkg::PIXEL_W),
    .DEPTH (256)
  ) u_shade (
    .clk     (clk),
    .we      (shade_we),
    .waddr   (table_addr[fcsm_pkg::PIXEL_W-1:0]),
    .wdata   (table_data),
    .raddr_a (shade_raddr_a),
    .raddr_b (shade_raddr_b),
    .rdata_a (shade_ceil),
    .rdata_b (shade_floor)
  );

  fcsm_shader u_shader (
    .clk             (clk),
    .rst             (rst),
    .column          (column),
    .tex_ceil        (tex_ceil),
    .tex_floor       (tex_floor),
    .shade_raddr_a   (shade_raddr_a),
    .shade_raddr_b   (shade_raddr_b),
    .shade_ceil      (shade_ceil),
    .shade_floor     (shade_floor),
    .draw_mode       (draw_mode),
    .shade_enable    (shade_enable),
    .pending         (pending),
    .strobe          (strobe),
    .ceiling_address (ceiling_address),
    .ceiling_valid   (ceiling_valid),
    .ceiling_pixel   (ceiling_pixel),
    .floor_address   (floor_address),
    .floor_valid     (floor_valid),
    .floor_pixel     (floor_pixel),
    .last            (last)
  );

  `FCSM_ASSERT_IMPL(a_strobe_follows_busy, strobe, $past(busy), "result without work in flight")
  `FCSM_ASSERT_NEXT(a_span_goes_busy, draw_load && (span_count != '0), busy,
    "span transfer did not start the walker")
  `FCSM_ASSERT_NEXT(a_last_ends_burst, strobe && last, !strobe, "result after final column")
  `FCSM_ASSERT_IMPL(a_valid_needs_strobe, !strobe, !ceiling_valid && !floor_valid && !last,
    "pixel flags outside a result")

endmodule
